/* src/lcs_pkg.sv */
// Shared constants, types, activation tables and fixed-point helpers of the LSTM cell.
`timescale 1ns / 1ps

package lcs_pkg;

    localparam int INPUT_SIZE      = 4;
    localparam int HIDDEN_SIZE     = 16;
    localparam int ACT_TABLE_DEPTH = 1024;
    localparam int ROWS_PER_GATE   = INPUT_SIZE + HIDDEN_SIZE + 1;
    localparam int WEIGHT_DEPTH    = 4 * ROWS_PER_GATE * HIDDEN_SIZE;

    localparam int WADDR_W = 11;
    localparam int ACC_W   = 40;
    localparam int ACT_W   = $clog2(ACT_TABLE_DEPTH);
    localparam int JW      = (HIDDEN_SIZE > 1) ? $clog2(HIDDEN_SIZE) : 1;
    localparam int RW      = $clog2(ROWS_PER_GATE);
    localparam int FW      = (INPUT_SIZE > 1) ? $clog2(INPUT_SIZE) : 1;

    localparam logic [1:0] GATE_I = 2'd0;
    localparam logic [1:0] GATE_F = 2'd1;
    localparam logic [1:0] GATE_G = 2'd2;
    localparam logic [1:0] GATE_O = 2'd3;

    localparam logic KIND_WEIGHT  = 1'b0;
    localparam logic KIND_FEATURE = 1'b1;

    localparam logic signed [15:0] BIAS_SCALE = 16'sd4096;

    typedef logic signed [15:0] act_rom_t [ACT_TABLE_DEPTH];

    typedef struct packed {
        logic mul_en;
        logic acc_clr;
        logic acc_en;
    } mac_ctrl_t;

    localparam longint ONE_Q30    = 64'sd1 << 30;
    localparam longint EXP_M1_Q30 = 64'sd395007543;

    // Shift-and-subtract quotient of two non-negative values, used only while building tables
    function automatic longint udiv(input longint n, input longint dv);
        longint q;
        longint rem;
        q   = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--) begin
            rem = (rem <<< 1) | ((n >>> b) & 64'sd1);
            if (rem >= dv) begin
                rem = rem - dv;
                q   = q | (64'sd1 << b);
            end
        end
        return q;
    endfunction

    // e^(-a) for a in Q16, result in Q30
    function automatic longint exp_neg_q30(input longint a);
        longint whole;
        longint frac;
        longint r;
        longint sum;
        longint term;
        whole = a >>> 16;
        frac  = a & 64'hFFFF;
        r     = ONE_Q30;
        sum   = ONE_Q30;
        term  = ONE_Q30;
        for (longint i = 0; i < whole; i++) begin
            r = (r * EXP_M1_Q30 + (ONE_Q30 >>> 1)) >>> 30;
        end
        for (int k = 1; k <= 14; k++) begin
            term = udiv((term * frac) >>> 16, longint'(k));
            sum  = ((k & 1) == 1) ? sum - term : sum + term;
        end
        return (r * sum + (ONE_Q30 >>> 1)) >>> 30;
    endfunction

    // Bin midpoints of [-8,8), rounded to nearest Q4.12
    function automatic act_rom_t build_rom(input bit is_tanh);
        act_rom_t rom;
        longint x;
        longint ax;
        longint e;
        longint d;
        longint e2;
        longint d2;
        longint s;
        longint t;
        for (int k = 0; k < ACT_TABLE_DEPTH; k++) begin
            x  = longint'(2 * k + 1) * 524288 / ACT_TABLE_DEPTH - 524288;
            ax = (x < 0) ? -x : x;
            e  = exp_neg_q30(ax);
            d  = ONE_Q30 + e;
            e2 = exp_neg_q30(2 * ax);
            d2 = ONE_Q30 + e2;
            if (x >= 0) s = udiv(4096 * ONE_Q30 + (d >>> 1), d);
            else        s = udiv(4096 * e + (d >>> 1), d);
            t = udiv(4096 * (ONE_Q30 - e2) + (d2 >>> 1), d2);
            if (x < 0) t = -t;
            rom[k] = is_tanh ? t[15:0] : s[15:0];
        end
        return rom;
    endfunction

    localparam act_rom_t SIGMOID_ROM = build_rom(1'b0);
    localparam act_rom_t TANH_ROM    = build_rom(1'b1);

    // Table bin of a Q4.12 value over [-8,8)
    function automatic logic [ACT_W-1:0] act_index(input logic signed [15:0] v);
        logic [31:0] u;
        logic [31:0] p;
        u = {16'd0, ~v[15], v[14:0]};
        p = u * 32'(ACT_TABLE_DEPTH);
        return p[16 +: ACT_W];
    endfunction

    // Round Q24 half up to Q12, saturate to 16 bits
    function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-13:0] q;
        t = v + ACC_W'(2048);
        q = t[ACC_W-1:12];
        if (q > (ACC_W-12)'(32767))       return 16'sh7FFF;
        else if (q < -(ACC_W-12)'(32768)) return 16'sh8000;
        else                              return q[15:0];
    endfunction

endpackage

/* src/lstm_cell_step.sv */
// Top level of the four-gate LSTM cell: item intake, step sequencer and result port.
`timescale 1ns / 1ps

// Usage:
//   The slave channel takes one transaction per item. tuser is the kind:
//   0 writes a Q4.12 weight or bias word, 1 delivers one input feature.
//   tlast marks the final feature of the input vector and runs one step.
//   The master channel returns HIDDEN_SIZE transactions per step, hidden
//   unit 0 first, tlast on the last one.
//   Weight writes and plain features are accepted back to back while the
//   sequencer is idle. A step runs one shared multiplier-accumulator over
//   every weight: per hidden unit and gate a clear state, products over the
//   ROWS_PER_GATE rows with drain and rounding, and a table lookup, then
//   the cell and hidden update and the hand-over of the result, which
//   waits while the output stalls. The weight store's single read port
//   sets the pace of a step.
//   s_tready is low for the whole step.
//   Reset clears the hidden and cell vectors and the sequencer; the weight
//   store and feature buffer hold nothing defined until written.
//   When the receiver stalls, the sequencer holds the pending result and
//   waits; no transaction is dropped.
module lstm_cell_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // weight_index[10:0], word_value[26:11], feature_index[28:27],
    // sequence_start[29], zero[31:30]
    input  logic [31:0] s_tdata,
    // kind[0]
    input  logic [0:0]  s_tuser,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // hidden_index[3:0], hidden_value[19:4], zero[23:20]
    output logic [23:0] m_tdata,
    output logic        m_tlast
);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CLR   = 14'b00000000000010,
        S_MAC   = 14'b00000000000100,
        S_DRAIN = 14'b00000000001000,
        S_ACT   = 14'b00000000010000,
        S_UA    = 14'b00000000100000,
        S_UB    = 14'b00000001000000,
        S_UC    = 14'b00000010000000,
        S_UD    = 14'b00000100000000,
        S_UE    = 14'b00001000000000,
        S_UF    = 14'b00010000000000,
        S_UG    = 14'b00100000000000,
        S_UH    = 14'b01000000000000,
        S_EMIT  = 14'b10000000000000
    } state_t;

    localparam int IN = lcs_pkg::INPUT_SIZE;
    localparam int H  = lcs_pkg::HIDDEN_SIZE;

    state_t state_reg, state_next;

    // Input fields
    logic                          in_kind;
    logic [lcs_pkg::WADDR_W-1:0]   in_widx;
    logic signed [15:0]            in_value;
    logic [1:0]                    in_fidx;
    logic                          in_start;
    logic                          in_acc;

    assign in_kind  = s_tuser[0];
    assign in_widx  = s_tdata[10:0];
    assign in_value = s_tdata[26:11];
    assign in_fidx  = s_tdata[28:27];
    assign in_start = s_tdata[29];
    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    // State storage
    logic signed [15:0] feature_reg [IN];
    logic signed [15:0] hidden_reg  [H];
    logic signed [15:0] cell_reg    [H];
    logic signed [15:0] hnew_reg    [H];
    logic signed [15:0] gate_reg    [4];

    logic [lcs_pkg::JW-1:0] j_reg;
    logic [1:0]             g_reg;
    logic [lcs_pkg::RW-1:0] r_reg;
    logic                   p1_reg, p2_reg;
    logic signed [15:0]     x_reg;
    logic signed [15:0]     pre_reg;
    logic signed [15:0]     c_reg;
    logic signed [15:0]     t_reg;

    logic                   m_tvalid_reg;
    logic [23:0]            m_tdata_reg;
    logic                   m_tlast_reg;

    // Weight store
    logic                        ram_we;
    logic [lcs_pkg::WADDR_W-1:0] ram_raddr;
    logic signed [15:0]          ram_rdata;
    int                          raddr_int;

    assign ram_we = in_acc && (in_kind == lcs_pkg::KIND_WEIGHT) &&
                    (32'(in_widx) < 32'(lcs_pkg::WEIGHT_DEPTH));
    assign raddr_int = (int'(g_reg) * lcs_pkg::ROWS_PER_GATE + int'(r_reg)) * H
                       + int'(j_reg);
    assign ram_raddr = raddr_int[lcs_pkg::WADDR_W-1:0];

    lcs_weight_ram u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (in_widx),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Operand for the current row: feature, old hidden value or bias scale
    logic signed [15:0]     x_next;
    logic [lcs_pkg::RW-1:0] hrow;

    assign hrow = r_reg - lcs_pkg::RW'(IN);

    always_comb begin
        if (32'(r_reg) < 32'(IN)) begin
            x_next = feature_reg[r_reg[lcs_pkg::FW-1:0]];
        end else if (32'(r_reg) < 32'(IN + H)) begin
            x_next = hidden_reg[hrow[lcs_pkg::JW-1:0]];
        end else begin
            x_next = lcs_pkg::BIAS_SCALE;
        end
    end

    // Shared MAC
    lcs_pkg::mac_ctrl_t         mac_ctrl;
    logic signed [15:0]         op_a, op_b;
    logic signed [lcs_pkg::ACC_W-1:0] acc;

    always_comb begin
        mac_ctrl = '0;
        op_a     = ram_rdata;
        op_b     = x_reg;
        case (state_reg)
            S_CLR: begin
                mac_ctrl.acc_clr = 1'b1;
            end
            S_UA: begin
                mac_ctrl.acc_clr = 1'b1;
                mac_ctrl.mul_en  = 1'b1;
                op_a = gate_reg[lcs_pkg::GATE_F];
                op_b = cell_reg[j_reg];
            end
            S_UB: begin
                mac_ctrl.acc_en = 1'b1;
                mac_ctrl.mul_en = 1'b1;
                op_a = gate_reg[lcs_pkg::GATE_I];
                op_b = gate_reg[lcs_pkg::GATE_G];
            end
            S_UC, S_UG: begin
                mac_ctrl.acc_en = 1'b1;
            end
            S_UF: begin
                mac_ctrl.acc_clr = 1'b1;
                mac_ctrl.mul_en  = 1'b1;
                op_a = gate_reg[lcs_pkg::GATE_O];
                op_b = t_reg;
            end
            default: begin
                mac_ctrl.mul_en = p1_reg;
                mac_ctrl.acc_en = p2_reg;
            end
        endcase
    end

    lcs_mac u_mac (
        .aclk  (aclk),
        .ctrl  (mac_ctrl),
        .op_a  (op_a),
        .op_b  (op_b),
        .acc   (acc)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && (in_kind == lcs_pkg::KIND_FEATURE) && s_tlast) begin
                    state_next = S_CLR;
                end
            end
            S_CLR:   state_next = S_MAC;
            S_MAC: begin
                if (32'(r_reg) == 32'(lcs_pkg::ROWS_PER_GATE - 1)) state_next = S_DRAIN;
            end
            S_DRAIN: begin
                if (!p1_reg && !p2_reg) state_next = S_ACT;
            end
            S_ACT: begin
                state_next = (g_reg == lcs_pkg::GATE_O) ? S_UA : S_CLR;
            end
            S_UA:    state_next = S_UB;
            S_UB:    state_next = S_UC;
            S_UC:    state_next = S_UD;
            S_UD:    state_next = S_UE;
            S_UE:    state_next = S_UF;
            S_UF:    state_next = S_UG;
            S_UG:    state_next = S_UH;
            S_UH:    state_next = S_EMIT;
            S_EMIT: begin
                if (m_tready) begin
                    state_next = (32'(j_reg) == 32'(H - 1)) ? S_IDLE : S_CLR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            p1_reg       <= 1'b0;
            p2_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
            j_reg        <= '0;
            g_reg        <= '0;
            r_reg        <= '0;
            for (int k = 0; k < H; k++) begin
                hidden_reg[k] <= '0;
                cell_reg[k]   <= '0;
            end
        end else begin
            state_reg <= state_next;
            p1_reg    <= (state_reg == S_MAC);
            p2_reg    <= p1_reg;

            case (state_reg)
                S_IDLE: begin
                    j_reg <= '0;
                    g_reg <= '0;
                    if (in_acc && (in_kind == lcs_pkg::KIND_FEATURE)) begin
                        if (in_start) begin
                            for (int k = 0; k < H; k++) begin
                                hidden_reg[k] <= '0;
                                cell_reg[k]   <= '0;
                            end
                        end
                    end
                end
                S_CLR: begin
                    r_reg <= '0;
                end
                S_MAC: begin
                    x_reg <= x_next;
                    r_reg <= r_reg + 1'b1;
                end
                S_DRAIN: begin
                    pre_reg <= lcs_pkg::round_sat(acc);
                end
                S_ACT: begin
                    gate_reg[g_reg] <= (g_reg == lcs_pkg::GATE_G) ?
                        lcs_pkg::TANH_ROM[lcs_pkg::act_index(pre_reg)] :
                        lcs_pkg::SIGMOID_ROM[lcs_pkg::act_index(pre_reg)];
                    g_reg <= g_reg + 1'b1;
                end
                S_UD: begin
                    c_reg           <= lcs_pkg::round_sat(acc);
                    cell_reg[j_reg] <= lcs_pkg::round_sat(acc);
                end
                S_UE: begin
                    t_reg <= lcs_pkg::TANH_ROM[lcs_pkg::act_index(c_reg)];
                end
                S_UH: begin
                    hnew_reg[j_reg] <= lcs_pkg::round_sat(acc);
                    m_tvalid_reg    <= 1'b1;
                    m_tdata_reg     <= {4'd0, lcs_pkg::round_sat(acc), 4'(j_reg)};
                    m_tlast_reg     <= (32'(j_reg) == 32'(H - 1));
                end
                S_EMIT: begin
                    if (m_tready) begin
                        m_tvalid_reg <= 1'b0;
                        j_reg        <= j_reg + 1'b1;
                        g_reg        <= '0;
                        if (32'(j_reg) == 32'(H - 1)) begin
                            // commit the new hidden vector once every unit used the old one
                            for (int k = 0; k < H; k++) begin
                                hidden_reg[k] <= hnew_reg[k];
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Feature buffer: payload only, no reset
    always_ff @(posedge aclk) begin
        if (in_acc && (in_kind == lcs_pkg::KIND_FEATURE) && (32'(in_fidx) < 32'(IN))) begin
            feature_reg[in_fidx[lcs_pkg::FW-1:0]] <= in_value;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

/* src/lcs_weight_ram.sv */
// Weight and bias store: one write port, one registered read port.
`timescale 1ns / 1ps

module lcs_weight_ram (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [lcs_pkg::WADDR_W-1:0]       waddr,
    input  logic signed [15:0]                wdata,
    input  logic [lcs_pkg::WADDR_W-1:0]       raddr,
    output logic signed [15:0]                rdata
);

    logic signed [15:0] mem [lcs_pkg::WEIGHT_DEPTH];
    logic signed [15:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/lcs_mac.sv */
// Shared multiplier with a registered product and a wide accumulator.
`timescale 1ns / 1ps

module lcs_mac (
    input  logic                              aclk,
    input  lcs_pkg::mac_ctrl_t                ctrl,
    input  logic signed [15:0]                op_a,
    input  logic signed [15:0]                op_b,
    output logic signed [lcs_pkg::ACC_W-1:0]  acc
);

    logic signed [31:0]               prod_reg;
    logic signed [lcs_pkg::ACC_W-1:0] acc_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= op_a * op_b;
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
        end else if (ctrl.acc_en) begin
            acc_reg <= acc_reg + lcs_pkg::ACC_W'(prod_reg);
        end
    end

    assign acc = acc_reg;

endmodule

/* dv/lstm_cell_step_tb.sv */
// Self-checking testbench of the four-gate LSTM cell: predicts every hidden result and checks it.
`timescale 1ns / 1ps

module lstm_cell_step_tb;

    localparam int  CLK_PERIOD  = 12;
    localparam int  QUIET_LIMIT = 30000;  // a step plus long stalls stays far below this
    localparam int  DRAIN_WAIT  = 50;
    localparam int  RX_HOLD_LEN = 4000;   // longer than one step, so the result side backs up
    localparam longint Q30      = 64'sd1 << 30;
    localparam longint EM1_Q30  = 64'sd395007543;

    typedef struct {
        logic [3:0]         idx;
        logic signed [15:0] val;
        logic               last;
    } hidden_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;

    // Model state of the cell
    logic signed [15:0] weight_mem [lcs_pkg::WEIGHT_DEPTH];
    logic signed [15:0] feat_mem   [lcs_pkg::INPUT_SIZE];
    logic signed [15:0] h_state    [lcs_pkg::HIDDEN_SIZE];
    logic signed [15:0] c_state    [lcs_pkg::HIDDEN_SIZE];
    logic signed [15:0] sig_lut    [lcs_pkg::ACT_TABLE_DEPTH];
    logic signed [15:0] tanh_lut   [lcs_pkg::ACT_TABLE_DEPTH];

    hidden_result_t hidden_expected[$];

    int  err_count;
    int  quiet_cycles;
    bit  tx_idle_en;
    bit  rx_idle_en;
    int  rx_hold_req;

    lstm_cell_step u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Fixed-point arithmetic of the cell
    // ------------------------------------------------------------------

    // e^(-a) with a in Q16, result in Q30
    function automatic longint neg_exp(input longint a);
        longint whole, frac, r, acc, term;
        whole = a >>> 16;
        frac  = a & 64'hFFFF;
        r     = Q30;
        acc   = Q30;
        term  = Q30;
        for (longint i = 0; i < whole; i++) r = (r * EM1_Q30 + (Q30 >>> 1)) >>> 30;
        for (int k = 1; k <= 14; k++) begin
            term = term * frac / 65536 / k;
            acc  = (k % 2 == 1) ? acc - term : acc + term;
        end
        return (r * acc + (Q30 >>> 1)) >>> 30;
    endfunction

    // Fill both activation tables with bin midpoints of [-8,8)
    task automatic fill_act_tables();
        longint x, ax, e, d, e2, d2, s, t;
        for (int k = 0; k < lcs_pkg::ACT_TABLE_DEPTH; k++) begin
            x  = longint'(2 * k + 1) * 524288 / lcs_pkg::ACT_TABLE_DEPTH - 524288;
            ax = (x < 0) ? -x : x;
            e  = neg_exp(ax);
            d  = Q30 + e;
            e2 = neg_exp(2 * ax);
            d2 = Q30 + e2;
            s  = (x >= 0) ? (4096 * Q30 + d / 2) / d : (4096 * e + d / 2) / d;
            t  = (4096 * (Q30 - e2) + d2 / 2) / d2;
            if (x < 0) t = -t;
            sig_lut[k]  = s[15:0];
            tanh_lut[k] = t[15:0];
        end
    endtask

    // Q24 back to Q12: round half up, then clamp to 16 bits
    function automatic logic signed [15:0] q24_to_q12(input longint v);
        longint q;
        q = (v + 2048) >>> 12;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic int act_bin(input logic signed [15:0] v);
        int b;
        b = ((int'(v) + 32768) * lcs_pkg::ACT_TABLE_DEPTH) >>> 16;
        return (b >= lcs_pkg::ACT_TABLE_DEPTH) ? lcs_pkg::ACT_TABLE_DEPTH - 1 : b;
    endfunction

    function automatic logic signed [15:0] gate_preact(input int gate, input int col);
        longint acc;
        int     base;
        acc  = 0;
        base = gate * lcs_pkg::ROWS_PER_GATE;
        for (int r = 0; r < lcs_pkg::INPUT_SIZE; r++)
            acc += longint'(feat_mem[r]) * weight_mem[(base + r) * lcs_pkg::HIDDEN_SIZE + col];
        for (int r = 0; r < lcs_pkg::HIDDEN_SIZE; r++)
            acc += longint'(h_state[r]) *
                   weight_mem[(base + lcs_pkg::INPUT_SIZE + r) * lcs_pkg::HIDDEN_SIZE + col];
        acc += longint'(weight_mem[(base + lcs_pkg::INPUT_SIZE + lcs_pkg::HIDDEN_SIZE) *
                                   lcs_pkg::HIDDEN_SIZE + col]) * 4096;
        return q24_to_q12(acc);
    endfunction

    // Apply one accepted item to the model; queue the hidden results of a step
    task automatic predict_hidden(input logic kind, input logic [10:0] widx,
                                  input logic signed [15:0] val, input logic [1:0] fidx,
                                  input logic last, input logic start);
        logic signed [15:0] ig [lcs_pkg::HIDDEN_SIZE];
        logic signed [15:0] fg [lcs_pkg::HIDDEN_SIZE];
        logic signed [15:0] gg [lcs_pkg::HIDDEN_SIZE];
        logic signed [15:0] og [lcs_pkg::HIDDEN_SIZE];
        hidden_result_t     res;
        if (kind == lcs_pkg::KIND_WEIGHT) begin
            if (widx < lcs_pkg::WEIGHT_DEPTH) weight_mem[widx] = val;
            return;
        end
        if (start) begin
            foreach (h_state[j]) begin
                h_state[j] = '0;
                c_state[j] = '0;
            end
        end
        if (fidx < lcs_pkg::INPUT_SIZE) feat_mem[fidx] = val;
        if (!last) return;
        for (int j = 0; j < lcs_pkg::HIDDEN_SIZE; j++) begin
            ig[j] = sig_lut[act_bin(gate_preact(lcs_pkg::GATE_I, j))];
            fg[j] = sig_lut[act_bin(gate_preact(lcs_pkg::GATE_F, j))];
            gg[j] = tanh_lut[act_bin(gate_preact(lcs_pkg::GATE_G, j))];
            og[j] = sig_lut[act_bin(gate_preact(lcs_pkg::GATE_O, j))];
        end
        for (int j = 0; j < lcs_pkg::HIDDEN_SIZE; j++) begin
            c_state[j] = q24_to_q12(longint'(fg[j]) * c_state[j] + longint'(ig[j]) * gg[j]);
            h_state[j] = q24_to_q12(longint'(og[j]) * tanh_lut[act_bin(c_state[j])]);
            res.idx  = 4'(j);
            res.val  = h_state[j];
            res.last = (j == lcs_pkg::HIDDEN_SIZE - 1);
            hidden_expected = {hidden_expected, res};
        end
    endtask

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Offer one transaction, hold it until accepted, then update the model
    task automatic send_item(input logic kind, input logic [10:0] widx,
                             input logic signed [15:0] val, input logic [1:0] fidx,
                             input logic last, input logic start);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tlast  <= last;
        s_tdata  <= {2'b00, start, fidx, val, widx};
        do @(posedge aclk); while (!s_tready);
        predict_hidden(kind, widx, val, fidx, last, start);
    endtask

    task automatic send_weight(input int idx, input logic signed [15:0] val);
        send_item(lcs_pkg::KIND_WEIGHT, 11'(idx), val, 2'($urandom), 1'b0, 1'($urandom));
    endtask

    // Deliver a full input vector in shuffled order, last flag on the final one
    task automatic send_vector(input bit start);
        int order[lcs_pkg::INPUT_SIZE];
        foreach (order[i]) order[i] = i;
        order.shuffle();
        foreach (order[i])
            send_item(lcs_pkg::KIND_FEATURE, 11'($urandom),
                      16'($urandom_range(0, 16383) - 8192),
                      2'(order[i]), i == lcs_pkg::INPUT_SIZE - 1, start && i == 0);
    endtask

    function automatic logic signed [15:0] rand_weight();
        case ($urandom_range(0, 19))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, 2047) - 1024);
        endcase
    endfunction

    task automatic idle_bus();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (hidden_expected.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready pattern and result check
    // ------------------------------------------------------------------

    int rx_gap;
    int rx_hold;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap   <= 0;
            rx_hold  <= 0;
        end else if (rx_hold_req > 0 && rx_hold == 0) begin
            // long hold-off: let the block fill up and stall its input
            rx_hold     <= rx_hold_req;
            rx_hold_req <= 0;
            m_tready    <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= (rx_hold == 1);
        end else if (rx_gap > 0) begin
            rx_gap   <= rx_gap - 1;
            m_tready <= (rx_gap == 1);
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_gap   <= $urandom_range(1, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        hidden_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (hidden_expected.size() == 0) begin
                report_mismatch("unexpected result, hidden_index", m_tdata[3:0], -1);
            end else begin
                want = hidden_expected.pop_front();
                if (m_tdata[3:0] !== want.idx)
                    report_mismatch("hidden_index", m_tdata[3:0], want.idx);
                if ($signed(m_tdata[19:4]) !== want.val)
                    report_mismatch("hidden_value", $signed(m_tdata[19:4]), want.val);
                if (m_tlast !== want.last)
                    report_mismatch("last_of_run", m_tlast, want.last);
                if (m_tdata[23:20] !== 4'd0)
                    report_mismatch("tdata pad", m_tdata[23:20], 0);
            end
        end
    end

    // Watchdog: count cycles in which neither side moves a transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("lstm_cell_step_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Load every weight and bias word so no step reads an unwritten entry
    task automatic test_weight_load();
        send_weight(0, 16'sh7FFF);
        send_weight(lcs_pkg::WEIGHT_DEPTH - 1, 16'sh8000);
        for (int i = 1; i < lcs_pkg::WEIGHT_DEPTH - 1; i++) send_weight(i, rand_weight());
    endtask

    task automatic test_directed();
        // feature extremes, first step from reset state
        send_item(lcs_pkg::KIND_FEATURE, 11'h7FF, 16'sh7FFF, 2'd0, 1'b0, 1'b0);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh8000, 2'd1, 1'b0, 1'b0);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh0000, 2'd2, 1'b0, 1'b0);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh1000, 2'd3, 1'b1, 1'b0);
        // a second step carries h and c forward
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'shF000, 2'd3, 1'b1, 1'b0);
        // out-of-range store writes are dropped; start flag on a write is ignored
        send_item(lcs_pkg::KIND_WEIGHT, 11'h7FF, 16'sh7FFF, 2'd3, 1'b0, 1'b1);
        send_item(lcs_pkg::KIND_WEIGHT, 11'(lcs_pkg::WEIGHT_DEPTH), 16'sh8000, 2'd0,
                  1'b0, 1'b0);
        // sequence start on a feature without the last flag clears state at once
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh0800, 2'd1, 1'b0, 1'b1);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh0800, 2'd2, 1'b1, 1'b0);
        // sequence start together with the last flag
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh7FFF, 2'd0, 1'b1, 1'b1);
        // overwrite bias words with extremes to saturate gates, then step
        send_weight((lcs_pkg::GATE_F * lcs_pkg::ROWS_PER_GATE + lcs_pkg::INPUT_SIZE +
                     lcs_pkg::HIDDEN_SIZE) * lcs_pkg::HIDDEN_SIZE, 16'sh7FFF);
        send_weight((lcs_pkg::GATE_O * lcs_pkg::ROWS_PER_GATE + lcs_pkg::INPUT_SIZE +
                     lcs_pkg::HIDDEN_SIZE) * lcs_pkg::HIDDEN_SIZE + 1, 16'sh8000);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh8000, 2'd2, 1'b1, 1'b0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_weight($urandom_range(0, 2047), rand_weight());
                    sent++;
                end
                2: begin
                    // stray feature with random flags
                    send_item(lcs_pkg::KIND_FEATURE, 11'($urandom), 16'($urandom),
                              2'($urandom), 1'($urandom), ($urandom_range(0, 7) == 0));
                    sent++;
                end
                default: begin
                    send_vector($urandom_range(0, 4) == 0);
                    sent += lcs_pkg::INPUT_SIZE;
                end
            endcase
        end
    endtask

    // Hold the result side off while the sender keeps offering steps
    task automatic test_backpressure();
        rx_hold_req <= RX_HOLD_LEN;
        send_vector(1'b1);
        send_vector(1'b0);
        send_item(lcs_pkg::KIND_FEATURE, 11'h000, 16'sh0400, 2'd1, 1'b1, 1'b0);
    endtask

    // Sender pauses until every expected result has arrived
    task automatic test_drain_pause();
        idle_bus();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        send_vector(1'b0);
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = '0;
        s_tlast     = 1'b0;
        m_tready    = 1'b0;
        err_count   = 0;
        quiet_cycles = 0;
        rx_hold_req = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        foreach (weight_mem[i]) weight_mem[i] = '0;
        foreach (feat_mem[i])   feat_mem[i]   = '0;
        foreach (h_state[i]) begin
            h_state[i] = '0;
            c_state[i] = '0;
        end
        fill_act_tables();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_idle_en = 1'b0;  // bulk load runs at full rate
        test_weight_load();
        tx_idle_en = 1'b1;
        test_directed();
        test_random_traffic(80);
        test_backpressure();
        test_drain_pause();
        // last part: no idling on either side
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random_traffic(30);

        idle_bus();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("lstm_cell_step_tb: PASS");
        end else begin
            $display("lstm_cell_step_tb: FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
src/lcs_pkg.sv
src/lcs_weight_ram.sv
src/lcs_mac.sv
src/lstm_cell_step.sv
dv/lstm_cell_step_tb.sv
